### rtl/stfc_pkg.sv
// Package for the serial trailer frame checker.
// Holds the sequencer state type, the status codes and the frame byte constants.
// Has no dependencies.
package stfc_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_CSUM,
    S_RD_LEN,
    S_CHK_LEN,
    S_RD_HDR,
    S_HDR,
    S_SUM,
    S_FIN,
    S_DONE
  } state_t;

  typedef logic [2:0] status_t;

  localparam status_t STAT_IDLE    = 3'd0;
  localparam status_t STAT_RESEND  = 3'd1;
  localparam status_t STAT_SINGLE  = 3'd2;
  localparam status_t STAT_DOUBLE  = 3'd3;
  localparam status_t STAT_IGNORED = 3'd4;

  localparam logic [7:0] TRAILER_BYTE = 8'h58;
  localparam logic [7:0] HEADER_BYTE  = 8'h17;
  localparam logic [7:0] CMD_SINGLE   = 8'hFF;
  localparam logic [7:0] CMD_DOUBLE   = 8'h0F;
  localparam logic [7:0] MAX_LENGTH   = 8'd251;
  localparam logic [7:0] MIN_PAYLOAD  = 8'd7;
  localparam logic [16:0] VALUE_OFFSET = 17'h08000;

endpackage

### rtl/serial_trailer_frame_checker.sv
// Serial trailer frame checker: byte store, backward frame check and command decode.
// Depends on stfc_pkg for the state type, status codes and frame constants.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+----------------------------------------------
//   input    | in_valid / in_ready   | action, rx_byte, line_disabled, rx_error
//   output   | out_valid / out_ready | status, not_trail, first_value, second_value,
//            |                       | period
//
// A byte that does not start a frame check goes from acceptance straight to the result.
// A trailer byte starts a walk over the store through its single read port, reading the
// checksum, the length, the header and then each payload byte, for a length up to 255.
// Reset clears the fill count and the capture block; the store needs no clearing.
// One transaction is in flight at a time; in_ready is low until the result is taken.
module serial_trailer_frame_checker #(
  parameter int BUFFER_DEPTH = 512,
  parameter int RETRY_LIMIT  = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [7:0]  rx_byte,
  input  logic        line_disabled,
  input  logic        rx_error,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic        not_trail,
  output logic [16:0] first_value,
  output logic [16:0] second_value,
  output logic [15:0] period
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);

  stfc_pkg::state_t state, state_next;

  logic [7:0]    mem [BUFFER_DEPTH];
  logic [7:0]    rd_data;
  logic          wr_en;

  logic [CW-1:0] count, count_next;
  logic          busy, busy_next;
  logic [AW-1:0] ptr, ptr_next;
  logic [7:0]    csum, csum_next;
  logic [7:0]    len, len_next;
  logic [7:0]    cnt, cnt_next;
  logic [7:0]    sum, sum_next;
  logic          hdr_ok, hdr_ok_next;
  logic [7:0]    pay [7];
  logic [7:0]    pay_next [7];

  logic [2:0]    status_next;
  logic          not_trail_next;
  logic [16:0]   first_value_next, second_value_next;
  logic [15:0]   period_next;

  logic          accept;
  logic          store_byte;
  logic          start_check;
  logic          len_bad;
  logic [CW-1:0] m;
  logic [7:0]    k;

  assign in_ready  = (state == stfc_pkg::S_IDLE);
  assign out_valid = (state == stfc_pkg::S_DONE);
  assign accept    = in_valid && in_ready;
  assign m         = count + CW'(1);

  assign store_byte = accept && !action && !line_disabled && !rx_error && !busy &&
                      (32'(count) < BUFFER_DEPTH);
  assign start_check = store_byte && (rx_byte == stfc_pkg::TRAILER_BYTE) &&
                       (m >= CW'(4));
  assign wr_en = store_byte;

  // In the length check, count already holds the number of stored bytes.
  assign len_bad = (rd_data == 8'd0) ||
                   ((CW+1)'(rd_data) + (CW+1)'(4) > (CW+1)'(count));

  // Payload position of the byte arriving on rd_data during the sum walk.
  assign k = len - cnt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[AW-1:0]] <= rx_byte;
    end
    rd_data <= mem[ptr];
  end

  always_comb begin
    state_next = state;
    case (state)
      stfc_pkg::S_IDLE: begin
        if (accept) begin
          state_next = start_check ? stfc_pkg::S_RD_CSUM : stfc_pkg::S_DONE;
        end
      end
      stfc_pkg::S_RD_CSUM: state_next = stfc_pkg::S_RD_LEN;
      stfc_pkg::S_RD_LEN:  state_next = stfc_pkg::S_CHK_LEN;
      stfc_pkg::S_CHK_LEN: state_next = len_bad ? stfc_pkg::S_FIN : stfc_pkg::S_RD_HDR;
      stfc_pkg::S_RD_HDR:  state_next = stfc_pkg::S_HDR;
      stfc_pkg::S_HDR:     state_next = stfc_pkg::S_SUM;
      stfc_pkg::S_SUM: begin
        if (cnt == 8'd1) begin
          state_next = stfc_pkg::S_FIN;
        end
      end
      stfc_pkg::S_FIN: state_next = stfc_pkg::S_DONE;
      stfc_pkg::S_DONE: begin
        if (out_ready) begin
          state_next = stfc_pkg::S_IDLE;
        end
      end
      default: state_next = stfc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    count_next        = count;
    busy_next         = busy;
    ptr_next          = ptr;
    csum_next         = csum;
    len_next          = len;
    cnt_next          = cnt;
    sum_next          = sum;
    hdr_ok_next       = hdr_ok;
    pay_next          = pay;
    status_next       = status;
    not_trail_next    = not_trail;
    first_value_next  = first_value;
    second_value_next = second_value;
    period_next       = period;
    case (state)
      stfc_pkg::S_IDLE: begin
        if (accept) begin
          status_next       = stfc_pkg::STAT_IDLE;
          not_trail_next    = 1'b0;
          first_value_next  = '0;
          second_value_next = '0;
          period_next       = '0;
          if (action) begin
            busy_next = 1'b0;
          end else if (line_disabled) begin
            status_next = stfc_pkg::STAT_IGNORED;
          end else if (rx_error) begin
            count_next  = '0;
            status_next = stfc_pkg::STAT_RESEND;
          end else if (busy) begin
            status_next = stfc_pkg::STAT_IGNORED;
          end else if (32'(count) >= BUFFER_DEPTH) begin
            count_next  = '0;
            status_next = stfc_pkg::STAT_RESEND;
          end else begin
            count_next = m;
            if (rx_byte != stfc_pkg::TRAILER_BYTE) begin
              not_trail_next = 1'b1;
            end
            // The checksum sits just below the trailer.
            ptr_next = AW'(count - CW'(1));
          end
        end
      end
      stfc_pkg::S_RD_CSUM: begin
        ptr_next = ptr - AW'(1);
      end
      stfc_pkg::S_RD_LEN: begin
        csum_next = rd_data;
      end
      stfc_pkg::S_CHK_LEN: begin
        len_next    = rd_data;
        cnt_next    = rd_data;
        sum_next    = 8'd0;
        hdr_ok_next = 1'b0;
        if (!len_bad) begin
          ptr_next = AW'(count - CW'(4) - CW'(rd_data));
        end
      end
      stfc_pkg::S_RD_HDR: begin
        ptr_next = ptr + AW'(1);
      end
      stfc_pkg::S_HDR: begin
        hdr_ok_next = (rd_data == stfc_pkg::HEADER_BYTE);
        ptr_next    = ptr + AW'(1);
      end
      stfc_pkg::S_SUM: begin
        sum_next = sum + rd_data;
        cnt_next = cnt - 8'd1;
        ptr_next = ptr + AW'(1);
        if (k < 8'd7) begin
          pay_next[k[2:0]] = rd_data;
        end
      end
      stfc_pkg::S_FIN: begin
        if ((sum != csum) || !hdr_ok) begin
          if (32'(count) > RETRY_LIMIT) begin
            count_next  = '0;
            status_next = stfc_pkg::STAT_RESEND;
          end else begin
            not_trail_next = 1'b1;
          end
        end else if (len > stfc_pkg::MAX_LENGTH) begin
          count_next  = '0;
          status_next = stfc_pkg::STAT_RESEND;
        end else if ((len >= stfc_pkg::MIN_PAYLOAD) &&
                     ((pay[0] == stfc_pkg::CMD_SINGLE) ||
                      (pay[0] == stfc_pkg::CMD_DOUBLE))) begin
          first_value_next  = 17'({pay[1], pay[2]}) + stfc_pkg::VALUE_OFFSET;
          second_value_next = 17'({pay[3], pay[4]}) + stfc_pkg::VALUE_OFFSET;
          period_next       = {pay[5], pay[6]};
          count_next        = '0;
          if (pay[0] == stfc_pkg::CMD_SINGLE) begin
            busy_next   = 1'b1;
            status_next = stfc_pkg::STAT_SINGLE;
          end else begin
            status_next = stfc_pkg::STAT_DOUBLE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stfc_pkg::S_IDLE;
      count <= '0;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      busy  <= busy_next;
    end
    ptr          <= ptr_next;
    csum         <= csum_next;
    len          <= len_next;
    cnt          <= cnt_next;
    sum          <= sum_next;
    hdr_ok       <= hdr_ok_next;
    pay          <= pay_next;
    status       <= status_next;
    not_trail    <= not_trail_next;
    first_value  <= first_value_next;
    second_value <= second_value_next;
    period       <= period_next;
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= BUFFER_DEPTH)
    else $error("stored byte count exceeds the buffer depth");

  a_single_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == stfc_pkg::STAT_SINGLE) |-> busy && (count == '0))
    else $error("single capture without block set or buffer cleared");

  a_double_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == stfc_pkg::STAT_DOUBLE) |-> (count == '0))
    else $error("double capture without buffer cleared");

  a_values_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != stfc_pkg::STAT_SINGLE) && (status != stfc_pkg::STAT_DOUBLE)
    |-> (first_value == '0) && (second_value == '0) && (period == '0))
    else $error("capture values present without a capture status");
`endif

endmodule

### dv/serial_trailer_frame_checker_test.sv
// Testbench for serial_trailer_frame_checker: directed and random byte traffic with a
// built-in frame predictor, random idling on both channels and one long output hold.
// Depends on stfc_pkg and the RTL of the frame checker.
`timescale 1ns / 100ps

module serial_trailer_frame_checker_test;

  localparam int BUFFER_DEPTH = 512;
  localparam int RETRY_LIMIT  = 256;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 300;

  localparam logic ACT_RECEIVE = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  typedef logic [7:0] octet_q_t [$];

  typedef struct packed {
    stfc_pkg::status_t status;
    logic              not_trail;
    logic [16:0]       first_value;
    logic [16:0]       second_value;
    logic [15:0]       period;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        action = ACT_RECEIVE;
  logic [7:0]  rx_byte = 8'h00;
  logic        line_disabled = 1'b0;
  logic        rx_error = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic        not_trail;
  logic [16:0] first_value;
  logic [16:0] second_value;
  logic [15:0] period;

  // Predictor state: a private copy of the byte store, fill count and capture block.
  logic [7:0]  store_copy [0:BUFFER_DEPTH-1];
  int unsigned fill_level = 0;
  bit          capture_block = 1'b0;

  frame_result_t pending_results [$];
  int unsigned   items_sent = 0;
  int unsigned   results_checked = 0;
  int unsigned   single_seen = 0;
  int unsigned   double_seen = 0;
  int unsigned   resend_seen = 0;
  int unsigned   errors = 0;
  int unsigned   gap_pct = 25;
  bit            quiet = 1'b0;
  bit            hold_pending = 1'b0;

  serial_trailer_frame_checker #(
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .RETRY_LIMIT (RETRY_LIMIT)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .rx_byte      (rx_byte),
    .line_disabled(line_disabled),
    .rx_error     (rx_error),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .not_trail    (not_trail),
    .first_value  (first_value),
    .second_value (second_value),
    .period       (period)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Works out the result of one transaction and advances the predictor state.
  function automatic frame_result_t frame_outcome(input logic act, input logic [7:0] data,
                                                  input logic off, input logic err);
    frame_result_t r;
    int unsigned   m;
    int unsigned   len;
    int unsigned   first;
    int unsigned   sum;
    logic [7:0]    cmd;
    bit            bad;
    r = '0;
    r.status = stfc_pkg::STAT_IDLE;
    bad = 1'b0;
    if (act == ACT_RELEASE) begin
      capture_block = 1'b0;
    end else if (off) begin
      r.status = stfc_pkg::STAT_IGNORED;
    end else if (err) begin
      fill_level = 0;
      r.status = stfc_pkg::STAT_RESEND;
    end else if (capture_block) begin
      r.status = stfc_pkg::STAT_IGNORED;
    end else if (fill_level >= BUFFER_DEPTH) begin
      fill_level = 0;
      r.status = stfc_pkg::STAT_RESEND;
    end else begin
      store_copy[fill_level] = data;
      fill_level++;
      m = fill_level;
      if (data != stfc_pkg::TRAILER_BYTE) begin
        r.not_trail = 1'b1;
      end else if (m >= 4) begin
        len = store_copy[m-3];
        if (len == 0 || len + 4 > m) begin
          bad = 1'b1;
        end else begin
          first = m - 3 - len;
          sum = 0;
          for (int i = 0; i < len; i++) sum += store_copy[first+i];
          cmd = store_copy[first];
          if (sum[7:0] != store_copy[m-2] ||
              store_copy[first-1] != stfc_pkg::HEADER_BYTE) begin
            bad = 1'b1;
          end else if (len > stfc_pkg::MAX_LENGTH) begin
            fill_level = 0;
            r.status = stfc_pkg::STAT_RESEND;
          end else if (len >= stfc_pkg::MIN_PAYLOAD &&
                       (cmd == stfc_pkg::CMD_SINGLE || cmd == stfc_pkg::CMD_DOUBLE)) begin
            r.first_value  = {1'b0, store_copy[first+1], store_copy[first+2]} +
                             stfc_pkg::VALUE_OFFSET;
            r.second_value = {1'b0, store_copy[first+3], store_copy[first+4]} +
                             stfc_pkg::VALUE_OFFSET;
            r.period       = {store_copy[first+5], store_copy[first+6]};
            fill_level = 0;
            if (cmd == stfc_pkg::CMD_SINGLE) begin
              capture_block = 1'b1;
              r.status = stfc_pkg::STAT_SINGLE;
            end else begin
              r.status = stfc_pkg::STAT_DOUBLE;
            end
          end
        end
        // A failed frame is kept unless the store has grown past the retry limit.
        if (bad) begin
          if (m > RETRY_LIMIT) begin
            fill_level = 0;
            r.status = stfc_pkg::STAT_RESEND;
          end else begin
            r.not_trail = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  task automatic send_item(input logic act, input logic [7:0] data,
                           input logic off, input logic err);
    in_valid      <= 1'b1;
    action        <= act;
    rx_byte       <= data;
    line_disabled <= off;
    rx_error      <= err;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(frame_outcome(act, data, off, err));
    items_sent++;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic send_data(input logic [7:0] data);
    send_item(ACT_RECEIVE, data, 1'b0, 1'b0);
  endtask

  task automatic send_release();
    send_item(ACT_RELEASE, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic clear_store();
    send_item(ACT_RECEIVE, 8'($urandom), 1'b0, 1'b1);
  endtask

  function automatic logic [7:0] filler_data();
    logic [7:0] d;
    d = 8'($urandom);
    return (d == stfc_pkg::TRAILER_BYTE) ? 8'h59 : d;
  endfunction

  function automatic octet_q_t random_body(input int unsigned len, input logic [7:0] cmd);
    octet_q_t body;
    for (int i = 0; i < len; i++) body.push_back(i == 0 ? cmd : 8'($urandom));
    return body;
  endfunction

  // Command byte followed by ones, so that no byte and no checksum looks like a trailer.
  function automatic octet_q_t plain_body(input int unsigned len, input logic [7:0] cmd);
    octet_q_t body;
    for (int i = 0; i < len; i++) body.push_back(i == 0 ? cmd : 8'h01);
    return body;
  endfunction

  function automatic octet_q_t capture_body(input logic [7:0] cmd, input logic [15:0] v1,
                                            input logic [15:0] v2, input logic [15:0] prd,
                                            input int unsigned extra);
    octet_q_t body;
    body = '{cmd, v1[15:8], v1[7:0], v2[15:8], v2[7:0], prd[15:8], prd[7:0]};
    repeat (extra) body.push_back(8'($urandom));
    return body;
  endfunction

  // Header, payload, length, checksum (offset by skew to corrupt it) and trailer.
  task automatic send_frame(input logic [7:0] hdr, input octet_q_t body,
                            input logic [7:0] len_byte, input logic [7:0] skew);
    logic [7:0] csum;
    csum = skew;
    foreach (body[i]) csum += body[i];
    send_data(hdr);
    foreach (body[i]) send_data(body[i]);
    send_data(len_byte);
    send_data(csum);
    send_data(stfc_pkg::TRAILER_BYTE);
  endtask

  task automatic test_control_items();
    send_release();
    send_data(stfc_pkg::TRAILER_BYTE);
    send_data(8'h00);
    send_data(8'hFF);
    send_data(stfc_pkg::TRAILER_BYTE);
    send_item(ACT_RECEIVE, 8'hFF, 1'b1, 1'b1);
    send_item(ACT_RECEIVE, 8'h00, 1'b1, 1'b0);
    clear_store();
    send_data(stfc_pkg::HEADER_BYTE);
    send_data(stfc_pkg::TRAILER_BYTE);
    send_item(ACT_RELEASE, 8'hA5, 1'b1, 1'b1);
  endtask

  task automatic test_capture_commands();
    octet_q_t body;
    clear_store();
    body = capture_body(stfc_pkg::CMD_SINGLE, 16'hFFFF, 16'h0000, 16'hFFFF, 0);
    send_frame(stfc_pkg::HEADER_BYTE, body, 8'd7, 8'h00);
    // While the single capture holds, every byte is dropped, a trailer included.
    send_data(8'h12);
    send_data(stfc_pkg::TRAILER_BYTE);
    send_item(ACT_RECEIVE, 8'h34, 1'b1, 1'b0);
    send_release();
    body = capture_body(stfc_pkg::CMD_DOUBLE, 16'h0000, 16'hFFFF, 16'h0000, 0);
    send_frame(stfc_pkg::HEADER_BYTE, body, 8'd7, 8'h00);
    body = capture_body(stfc_pkg::CMD_DOUBLE, 16'h8001, 16'h7FFE, 16'h1234, 13);
    send_frame(stfc_pkg::HEADER_BYTE, body, 8'd20, 8'h00);
    // Commands that decode to nothing: too short, or an unknown command byte.
    body = random_body(6, stfc_pkg::CMD_SINGLE);
    send_frame(stfc_pkg::HEADER_BYTE, body, 8'd6, 8'h00);
    body = random_body(9, 8'h00);
    send_frame(stfc_pkg::HEADER_BYTE, body, 8'd9, 8'h00);
  endtask

  task automatic test_bad_frames();
    octet_q_t body;
    clear_store();
    send_frame(stfc_pkg::HEADER_BYTE, body, 8'd0, 8'h00);
    clear_store();
    send_data(8'h03);
    send_data(8'd10);
    send_data(8'h03);
    send_data(stfc_pkg::TRAILER_BYTE);
    body = capture_body(stfc_pkg::CMD_DOUBLE, 16'h1111, 16'h2222, 16'h3333, 1);
    send_frame(stfc_pkg::HEADER_BYTE, body, 8'd8, 8'h01);
    send_frame(8'h16, body, 8'd8, 8'h00);
  endtask

  // Fills the store to its depth; a failed frame at exactly the retry limit keeps its
  // bytes and a longest legal frame without a command is kept as well.
  task automatic test_full_store();
    octet_q_t body;
    clear_store();
    body = plain_body(240, 8'h00);
    send_frame(stfc_pkg::HEADER_BYTE, body, 8'd240, 8'h00);
    body = plain_body(8, 8'h00);
    send_frame(stfc_pkg::HEADER_BYTE, body, 8'd8, 8'h01);
    body = plain_body(stfc_pkg::MAX_LENGTH, 8'h00);
    send_frame(stfc_pkg::HEADER_BYTE, body, stfc_pkg::MAX_LENGTH, 8'h00);
    send_data(filler_data());
    send_data(stfc_pkg::TRAILER_BYTE);
    send_data(stfc_pkg::TRAILER_BYTE);
  endtask

  // Past the retry limit a failed frame clears the store and asks for a resend.
  task automatic test_retry_limit();
    octet_q_t body;
    clear_store();
    send_data(filler_data());
    body = plain_body(stfc_pkg::MAX_LENGTH + 1, 8'h00);
    send_frame(stfc_pkg::HEADER_BYTE, body, 8'(stfc_pkg::MAX_LENGTH + 1), 8'h01);
  endtask

  task automatic test_overlong_frames();
    octet_q_t body;
    clear_store();
    body = plain_body(stfc_pkg::MAX_LENGTH + 1, stfc_pkg::CMD_DOUBLE);
    send_frame(stfc_pkg::HEADER_BYTE, body, 8'(stfc_pkg::MAX_LENGTH + 1), 8'h00);
  endtask

  task automatic test_random_traffic(input int unsigned count);
    int unsigned stop_at;
    int unsigned kind;
    int unsigned len;
    int unsigned pick;
    logic [7:0]  cmd;
    logic [7:0]  hdr;
    logic [7:0]  len_byte;
    logic [7:0]  skew;
    octet_q_t    body;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) len = $urandom_range(7, 20);
        else if (pick < 95) len = $urandom_range(0, 6);
        else len = $urandom_range(200, 255);
        pick = $urandom_range(0, 9);
        cmd = (pick < 4) ? stfc_pkg::CMD_SINGLE :
              (pick < 8) ? stfc_pkg::CMD_DOUBLE : 8'($urandom);
        body = random_body(len, cmd);
        hdr = ($urandom_range(0, 9) == 0) ? 8'($urandom) : stfc_pkg::HEADER_BYTE;
        len_byte = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'(len);
        skew = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 4)) send_data(8'($urandom));
        end
        send_frame(hdr, body, len_byte, skew);
        if (capture_block && $urandom_range(0, 1) == 0) send_release();
      end else if (kind < 75) begin
        repeat ($urandom_range(1, 5)) send_data(8'($urandom));
      end else if (kind < 88) begin
        send_release();
      end else if (kind < 95) begin
        send_item(1'($urandom), 8'($urandom), 1'b1, 1'($urandom));
      end else begin
        send_item(ACT_RECEIVE, 8'($urandom), 1'b0, 1'b1);
      end
    end
  endtask

  // The receiver stops taking results for a long stretch while frames keep coming.
  task automatic test_output_hold();
    hold_pending = 1'b1;
    test_random_traffic(50);
  endtask

  initial begin
    @(posedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < gap_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, actual status %0d", $time, status);
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, status);
        check_field("not_trail", want.not_trail, not_trail);
        check_field("first_value", want.first_value, first_value);
        check_field("second_value", want.second_value, second_value);
        check_field("period", want.period, period);
        results_checked++;
        if (want.status == stfc_pkg::STAT_SINGLE) single_seen++;
        if (want.status == stfc_pkg::STAT_DOUBLE) double_seen++;
        if (want.status == stfc_pkg::STAT_RESEND) resend_seen++;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_control_items();
    test_capture_commands();
    test_bad_frames();
    test_full_store();
    test_retry_limit();
    test_overlong_frames();
    gap_pct = 40;
    test_random_traffic(110);
    gap_pct = 10;
    test_random_traffic(80);
    test_output_hold();
    quiet = 1'b1;
    test_random_traffic(40);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d transactions and checked %0d results.", items_sent, results_checked);
    $display("Seen %0d single captures, %0d double captures and %0d resend requests.",
             single_seen, double_seen, resend_seen);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
